>>> rtl/two_button_press_decoder_top_macros.svh
// Assertion macros for the two-button press decoder.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TWO_BUTTON_PRESS_DECODER_TOP_MACROS_SVH
`define TWO_BUTTON_PRESS_DECODER_TOP_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define TBPD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define TBPD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/tbpd_pkg.sv
// Shared types and constants for the two-button press decoder.
// No dependencies; used by the core, the result register and the top level.
package tbpd_pkg;

    // Fixed field widths.
    localparam int TIME_IN_W = 32;
    localparam int LPT_W     = 16;

    // Defaults.
    localparam int              TIME_BITS_DEFAULT = 32;
    localparam logic [LPT_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Button pattern codes: left is bit 1, right is bit 0.
    typedef enum logic [1:0] {
        BTN_NONE  = 2'b00,
        BTN_RIGHT = 2'b01,
        BTN_LEFT  = 2'b10,
        BTN_BOTH  = 2'b11
    } btn_t;

    // One input sample word.
    typedef struct packed {
        logic                 left_pressed;
        logic                 right_pressed;
        logic [TIME_IN_W-1:0] time_now;
    } sample_t;

    // One result word.
    typedef struct packed {
        logic left_short;
        logic right_short;
        logic left_long;
        logic right_long;
        logic mode_changed;
        logic mode_now;
    } result_t;

endpackage

>>> rtl/tbpd_core.sv
// Decode core: button state registers and the per-sample decode logic.
// Depends on tbpd_pkg.
module tbpd_core #(
    parameter int TIME_BITS = tbpd_pkg::TIME_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [tbpd_pkg::LPT_W-1:0]  cfg_write_data,
    input  logic                        step,
    input  tbpd_pkg::sample_t           sample,
    output tbpd_pkg::result_t           result
);

    logic [tbpd_pkg::LPT_W-1:0] lpt_reg;
    logic                       left_prev_reg, right_prev_reg;
    logic [TIME_BITS-1:0]       left_start_reg, right_start_reg;
    logic                       left_done_reg, right_done_reg;
    logic                       chord_reg, mode_reg;

    logic                       left_done_next, right_done_next;
    logic [TIME_BITS-1:0]       left_start_next, right_start_next;
    logic                       chord_next, mode_next;

    logic [TIME_BITS-1:0]       now;
    logic [TIME_BITS-1:0]       limit;
    logic [TIME_BITS-1:0]       left_held, right_held;
    logic                       left_edge, right_edge;
    logic                       left_done_eff, right_done_eff;
    logic                       left_long, right_long;
    tbpd_pkg::btn_t             cur, prev;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpt_reg <= tbpd_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_write_en)
        begin
            lpt_reg <= cfg_write_data;
        end
    end

    // Press edges restart the hold timer and the long-press mark.
    always_comb
    begin
        now   = TIME_BITS'(sample.time_now);
        limit = TIME_BITS'(lpt_reg);
        cur   = tbpd_pkg::btn_t'({sample.left_pressed, sample.right_pressed});
        prev  = tbpd_pkg::btn_t'({left_prev_reg, right_prev_reg});

        left_edge  = sample.left_pressed && !left_prev_reg;
        right_edge = sample.right_pressed && !right_prev_reg;

        left_start_next  = left_edge ? now : left_start_reg;
        right_start_next = right_edge ? now : right_start_reg;
        left_done_eff    = left_edge ? 1'b0 : left_done_reg;
        right_done_eff   = right_edge ? 1'b0 : right_done_reg;

        // Wrapping hold time against the limit.
        left_held  = now - left_start_next;
        right_held = now - right_start_next;
        left_long  = sample.left_pressed && !left_done_eff && (left_held >= limit);
        right_long = sample.right_pressed && !right_done_eff && (right_held >= limit);
    end

    // Chord tracking, release handling and result assembly.
    always_comb
    begin
        left_done_next  = left_done_eff || left_long;
        right_done_next = right_done_eff || right_long;
        chord_next      = chord_reg || (cur == tbpd_pkg::BTN_BOTH);
        mode_next       = mode_reg;

        result              = '0;
        result.left_long    = left_long;
        result.right_long   = right_long;

        if ((cur == tbpd_pkg::BTN_NONE) && (prev != tbpd_pkg::BTN_NONE))
        begin
            if (chord_next)
            begin
                mode_next           = !mode_reg;
                result.mode_changed = 1'b1;
                chord_next          = 1'b0;
            end
            else if (prev == tbpd_pkg::BTN_RIGHT)
            begin
                result.right_short = !right_done_next;
            end
            else if (prev == tbpd_pkg::BTN_LEFT)
            begin
                result.left_short = !left_done_next;
            end
            if (right_prev_reg)
            begin
                right_done_next = 1'b0;
            end
            if (left_prev_reg)
            begin
                left_done_next = 1'b0;
            end
        end

        result.mode_now = mode_next;
    end

    // State registers advance once per decoded sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_prev_reg   <= 1'b0;
            right_prev_reg  <= 1'b0;
            left_start_reg  <= '0;
            right_start_reg <= '0;
            left_done_reg   <= 1'b0;
            right_done_reg  <= 1'b0;
            chord_reg       <= 1'b0;
            mode_reg        <= 1'b0;
        end
        else if (step)
        begin
            left_prev_reg   <= sample.left_pressed;
            right_prev_reg  <= sample.right_pressed;
            left_start_reg  <= left_start_next;
            right_start_reg <= right_start_next;
            left_done_reg   <= left_done_next;
            right_done_reg  <= right_done_next;
            chord_reg       <= chord_next;
            mode_reg        <= mode_next;
        end
    end

endmodule

>>> rtl/tbpd_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on tbpd_pkg.
module tbpd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tbpd_pkg::result_t result_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output tbpd_pkg::result_t result_out
);

    logic              valid_reg;
    tbpd_pkg::result_t data_reg;

    // The register takes a new word when empty or while its word leaves.
    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // Payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

>>> rtl/two_button_press_decoder_top.sv
// Two-button press decoder. Each input word is one sample of both button levels plus a
// free-running millisecond timestamp; each produces exactly one result word with
// short-press, long-press and mode-change events and the current mode. A word goes
// through an input register, a combinational decode against the button state
// registers and a result register, and one word is accepted every cycle as long as
// the consumer keeps taking results. The hold limit in long_press_time (reset 1000 ms)
// is written through cfg_write_en / cfg_write_data and should only change while the
// block is idle.
// Depends on tbpd_pkg, tbpd_core, tbpd_out_reg and the macros header.
`include "two_button_press_decoder_top_macros.svh"

module two_button_press_decoder_top #(
    parameter int TIME_BITS = tbpd_pkg::TIME_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [tbpd_pkg::LPT_W-1:0]     cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           left_pressed,
    input  logic                           right_pressed,
    input  logic [tbpd_pkg::TIME_IN_W-1:0] time_now,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           left_short,
    output logic                           right_short,
    output logic                           left_long,
    output logic                           right_long,
    output logic                           mode_changed,
    output logic                           mode_now
);

    logic              in_valid_reg;
    tbpd_pkg::sample_t sample_reg;
    logic              can_load;
    logic              step;
    tbpd_pkg::result_t core_result;
    tbpd_pkg::result_t out_result;

    // The input register moves on whenever the result register can take a word.
    assign step     = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || can_load;

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg.left_pressed  <= left_pressed;
            sample_reg.right_pressed <= right_pressed;
            sample_reg.time_now      <= time_now;
        end
    end

    // Decode core.
    tbpd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .step           (step),
        .sample         (sample_reg),
        .result         (core_result)
    );

    // Result register.
    tbpd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (core_result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    assign left_short   = out_result.left_short;
    assign right_short  = out_result.right_short;
    assign left_long    = out_result.left_long;
    assign right_long   = out_result.right_long;
    assign mode_changed = out_result.mode_changed;
    assign mode_now     = out_result.mode_now;

    // Only one lone button can be reported released.
    `TBPD_ASSERT_IMPLY(a_one_short, out_valid, !(left_short && right_short), "both short events set")

    // A chord release carries no other event.
    `TBPD_ASSERT_IMPLY(a_chord_alone, out_valid && mode_changed, !(left_short || right_short || left_long || right_long), "mode change mixed with button event")

    // An empty result register never blocks the input side.
    `TBPD_ASSERT_IMPLY(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty result register")

endmodule

>>> dv/tb_two_button_press_decoder_top.sv
// Self-checking testbench for two_button_press_decoder_top.
// Holds its own button decoder predictor and a scripted plus random stimulus.
// Depends on tbpd_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_two_button_press_decoder_top;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_PAD      = 4;
    localparam int LONG_HOLD      = 60;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 155;
    localparam int MAX_PRINTED    = 30;
    localparam int SCRIPT_ROWS    = 30;

    // Kinds of scripted rows: a limit write, or a sample with a typed or predicted result.
    typedef enum logic [1:0] {
        ROW_LIMIT,
        ROW_TYPED,
        ROW_PREDICTED
    } row_kind_t;

    // For a limit row the new limit sits in the low bits of stamp.
    typedef struct packed {
        row_kind_t                      kind;
        tbpd_pkg::btn_t                 buttons;
        logic [tbpd_pkg::TIME_IN_W-1:0] stamp;
        tbpd_pkg::result_t              want;
    } script_row_t;

    // Result fields, MSB first: left_short right_short left_long right_long
    // mode_changed mode_now.
    script_row_t script [SCRIPT_ROWS] = '{
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd0,          6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_LEFT,  32'd100,        6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd600,        6'b100000},
        '{ROW_TYPED,     tbpd_pkg::BTN_RIGHT, 32'd1000,       6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_RIGHT, 32'd2000,       6'b000100},
        '{ROW_TYPED,     tbpd_pkg::BTN_RIGHT, 32'd3000,       6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd3100,       6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_LEFT,  32'hFFFF_FF00,  6'b000000},
        '{ROW_PREDICTED, tbpd_pkg::BTN_LEFT,  32'h0000_0100,  6'b000000},
        '{ROW_PREDICTED, tbpd_pkg::BTN_LEFT,  32'h0000_0300,  6'b000000},
        '{ROW_PREDICTED, tbpd_pkg::BTN_BOTH,  32'h0000_0400,  6'b000000},
        '{ROW_PREDICTED, tbpd_pkg::BTN_RIGHT, 32'h0000_0500,  6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'h0000_0600,  6'b000011},
        '{ROW_TYPED,     tbpd_pkg::BTN_LEFT,  32'd5000,       6'b000001},
        '{ROW_TYPED,     tbpd_pkg::BTN_LEFT,  32'd4000,       6'b001001},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd4100,       6'b000001},
        '{ROW_TYPED,     tbpd_pkg::BTN_BOTH,  32'hFFFF_FFFF,  6'b000001},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd0,          6'b000010},
        '{ROW_TYPED,     tbpd_pkg::BTN_RIGHT, 32'd10,         6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd20,         6'b010000},
        '{ROW_LIMIT,     tbpd_pkg::BTN_NONE,  32'd0,          6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_LEFT,  32'd7,          6'b001000},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd8,          6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_BOTH,  32'd9,          6'b001100},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd10,         6'b000011},
        '{ROW_LIMIT,     tbpd_pkg::BTN_NONE,  32'd65535,      6'b000000},
        '{ROW_TYPED,     tbpd_pkg::BTN_RIGHT, 32'd0,          6'b000001},
        '{ROW_PREDICTED, tbpd_pkg::BTN_RIGHT, 32'd65534,      6'b000001},
        '{ROW_TYPED,     tbpd_pkg::BTN_RIGHT, 32'd65535,      6'b000101},
        '{ROW_TYPED,     tbpd_pkg::BTN_NONE,  32'd65536,      6'b000001}
    };

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [tbpd_pkg::LPT_W-1:0]     cfg_write_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           left_pressed;
    logic                           right_pressed;
    logic [tbpd_pkg::TIME_IN_W-1:0] time_now;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           left_short;
    logic                           right_short;
    logic                           left_long;
    logic                           right_long;
    logic                           mode_changed;
    logic                           mode_now;

    // Predictor state.
    logic [tbpd_pkg::LPT_W-1:0]     hold_limit;
    logic                           held_left;
    logic                           held_right;
    logic [tbpd_pkg::TIME_IN_W-1:0] start_left;
    logic [tbpd_pkg::TIME_IN_W-1:0] start_right;
    logic                           left_fired;
    logic                           right_fired;
    logic                           chord_flag;
    logic                           mode_bit;

    tbpd_pkg::result_t              pending_results [$];
    logic [tbpd_pkg::TIME_IN_W-1:0] clock_ms;
    bit                             idle_on;
    logic                           long_hold_req;
    logic                           sink_hold;
    int                             sink_gap = 0;
    int                             error_count = 0;
    int                             cycle_count = 0;
    int                             items_sent;
    int                             words_checked = 0;
    int                             limits_written;
    int                             input_stall_cycles = 0;
    int                             shorts_seen = 0;
    int                             longs_seen = 0;
    int                             toggles_seen = 0;

    two_button_press_decoder_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_pressed   (left_pressed),
        .right_pressed  (right_pressed),
        .time_now       (time_now),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_short     (left_short),
        .right_short    (right_short),
        .left_long      (left_long),
        .right_long     (right_long),
        .mode_changed   (mode_changed),
        .mode_now       (mode_now)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Works out the result of one sample and advances the predictor state.
    function automatic tbpd_pkg::result_t decode_sample(input logic l, input logic r,
                                                        input logic [tbpd_pkg::TIME_IN_W-1:0] t);
        tbpd_pkg::result_t res;
        tbpd_pkg::btn_t    now_btn;
        tbpd_pkg::btn_t    was_btn;
        res     = '0;
        now_btn = tbpd_pkg::btn_t'({l, r});
        was_btn = tbpd_pkg::btn_t'({held_left, held_right});

        // A press edge restarts the hold timer of that button.
        if (l && !held_left)
        begin
            start_left = t;
            left_fired = 1'b0;
        end
        if (r && !held_right)
        begin
            start_right = t;
            right_fired = 1'b0;
        end

        // Long press fires once per hold; the hold time wraps with the timestamp.
        if (l && !left_fired && (t - start_left) >= {16'd0, hold_limit})
        begin
            res.left_long = 1'b1;
            left_fired    = 1'b1;
        end
        if (r && !right_fired && (t - start_right) >= {16'd0, hold_limit})
        begin
            res.right_long = 1'b1;
            right_fired    = 1'b1;
        end

        if (now_btn == tbpd_pkg::BTN_BOTH)
            chord_flag = 1'b1;

        // Release to none: a chord toggles the mode, a lone button may give a short press.
        if (now_btn == tbpd_pkg::BTN_NONE && was_btn != tbpd_pkg::BTN_NONE)
        begin
            if (chord_flag)
            begin
                mode_bit         = ~mode_bit;
                res.mode_changed = 1'b1;
                chord_flag       = 1'b0;
            end
            else if (was_btn == tbpd_pkg::BTN_RIGHT)
                res.right_short = ~right_fired;
            else if (was_btn == tbpd_pkg::BTN_LEFT)
                res.left_short = ~left_fired;
            if (was_btn[0])
                right_fired = 1'b0;
            if (was_btn[1])
                left_fired = 1'b0;
        end

        held_left    = l;
        held_right   = r;
        res.mode_now = mode_bit;
        return res;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Compares one result word with the oldest expectation, field by field.
    task automatic check_result(input tbpd_pkg::result_t got);
        tbpd_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report_error($sformatf("result word %b with no expectation waiting", got));
            return;
        end
        want = pending_results.pop_front();
        if (got.left_short !== want.left_short)
            report_error($sformatf("word %0d left_short got %b want %b",
                                   words_checked, got.left_short, want.left_short));
        if (got.right_short !== want.right_short)
            report_error($sformatf("word %0d right_short got %b want %b",
                                   words_checked, got.right_short, want.right_short));
        if (got.left_long !== want.left_long)
            report_error($sformatf("word %0d left_long got %b want %b",
                                   words_checked, got.left_long, want.left_long));
        if (got.right_long !== want.right_long)
            report_error($sformatf("word %0d right_long got %b want %b",
                                   words_checked, got.right_long, want.right_long));
        if (got.mode_changed !== want.mode_changed)
            report_error($sformatf("word %0d mode_changed got %b want %b",
                                   words_checked, got.mode_changed, want.mode_changed));
        if (got.mode_now !== want.mode_now)
            report_error($sformatf("word %0d mode_now got %b want %b",
                                   words_checked, got.mode_now, want.mode_now));
        shorts_seen   += want.left_short + want.right_short;
        longs_seen    += want.left_long + want.right_long;
        toggles_seen  += want.mode_changed;
        words_checked++;
    endtask

    // Offers one sample word and waits for it to be taken; may idle afterwards.
    task automatic send_sample(input tbpd_pkg::btn_t buttons,
                               input logic [tbpd_pkg::TIME_IN_W-1:0] stamp,
                               input bit typed, input tbpd_pkg::result_t typed_want);
        tbpd_pkg::result_t predicted;
        in_valid      <= 1'b1;
        left_pressed  <= buttons[1];
        right_pressed <= buttons[0];
        time_now      <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = decode_sample(buttons[1], buttons[0], stamp);
        pending_results.insert(pending_results.size(), typed ? typed_want : predicted);
        items_sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stops offering words until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Writes the hold limit while the block is idle.
    task automatic set_limit(input logic [tbpd_pkg::LPT_W-1:0] value);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        hold_limit = value;
        limits_written++;
    endtask

    // Advances the millisecond clock by up to span and sends one sample.
    task automatic emit(input tbpd_pkg::btn_t buttons, input int unsigned span);
        clock_ms = clock_ms + $urandom_range(0, span);
        send_sample(buttons, clock_ms, 1'b0, '0);
    endtask

    // One random gesture: short press, long hold, chord, or noise samples.
    task automatic play_gesture();
        int unsigned    short_span;
        int unsigned    long_span;
        int unsigned    pick;
        tbpd_pkg::btn_t one;
        short_span = hold_limit / 6 + 1;
        long_span  = hold_limit / 2 + 1;
        pick       = $urandom_range(0, 99);
        one        = $urandom_range(0, 1) ? tbpd_pkg::BTN_LEFT : tbpd_pkg::BTN_RIGHT;

        // Now and then start the gesture just before the timestamp wraps.
        if ($urandom_range(0, 19) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, hold_limit);

        if (pick < 30)
        begin
            emit(one, short_span);
            repeat ($urandom_range(0, 3)) emit(one, short_span);
            emit(tbpd_pkg::BTN_NONE, short_span);
        end
        else if (pick < 55)
        begin
            emit(one, short_span);
            repeat ($urandom_range(1, 4)) emit(one, long_span);
            emit(tbpd_pkg::BTN_NONE, short_span);
        end
        else if (pick < 85)
        begin
            emit(pick[0] ? one : tbpd_pkg::BTN_BOTH, short_span);
            repeat ($urandom_range(1, 3)) emit(tbpd_pkg::BTN_BOTH, long_span);
            if ($urandom_range(0, 1))
                emit(one, short_span);
            emit(tbpd_pkg::BTN_NONE, short_span);
        end
        else
        begin
            // Noise: random levels, with timestamps that may jump anywhere.
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 2) == 0)
                    clock_ms = $urandom;
                emit(tbpd_pkg::btn_t'($urandom_range(0, 3)), long_span);
            end
        end
    endtask

    // Result side: checks accepted words and drives out_ready with random stalls.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result({left_short, right_short, left_long, right_long,
                          mode_changed, mode_now});
        if (in_valid && !in_ready)
            input_stall_cycles++;
        if (sink_gap > 0)
            sink_gap--;
        else if (idle_on && $urandom_range(0, 5) == 0)
            sink_gap = $urandom_range(1, 6);
        out_ready <= rst_n && !sink_hold && sink_gap == 0;
    end

    // Long receiver hold-off, so the block fills and stalls its input.
    initial
    begin
        sink_hold = 1'b0;
        wait (long_hold_req);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("two_button_press_decoder_top regression: fail");
            $finish;
        end
    end

    // Main sequence: reset, scripted words, then random phases at several limits.
    initial
    begin
        logic [tbpd_pkg::LPT_W-1:0] phase_limit [PHASES];
        int                         phase_start;
        bit                         paused;

        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = '0;
        in_valid           = 1'b0;
        left_pressed       = 1'b0;
        right_pressed      = 1'b0;
        time_now           = '0;
        long_hold_req      = 1'b0;
        idle_on            = 1'b1;
        items_sent         = 0;
        limits_written     = 0;
        clock_ms           = '0;
        paused             = 1'b0;

        hold_limit  = tbpd_pkg::LONG_PRESS_RESET;
        held_left   = 1'b0;
        held_right  = 1'b0;
        start_left  = '0;
        start_right = '0;
        left_fired  = 1'b0;
        right_fired = 1'b0;
        chord_flag  = 1'b0;
        mode_bit    = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted words from the reset state.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_LIMIT)
                set_limit(script[i].stamp[tbpd_pkg::LPT_W-1:0]);
            else
                send_sample(script[i].buttons, script[i].stamp,
                            script[i].kind == ROW_TYPED, script[i].want);
        end

        // Random phases; the last one runs with no idling on either side.
        phase_limit    = '{16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd37, tbpd_pkg::LONG_PRESS_RESET};
        phase_limit[3] = 16'($urandom_range(2, 5000));
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            set_limit(phase_limit[ph]);
            if (ph == 1)
                long_hold_req <= 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                play_gesture();
                if (ph == 2 && !paused && items_sent - phase_start > PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        // Let everything drain, then report.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);

        $display("Checked %0d result words from %0d samples over %0d limit settings.",
                 words_checked, items_sent, limits_written);
        $display("Events: %0d short, %0d long, %0d mode toggles; %0d input stall cycles.",
                 shorts_seen, longs_seen, toggles_seen, input_stall_cycles);
        if (error_count == 0)
            $display("two_button_press_decoder_top regression: pass");
        else
            $display("two_button_press_decoder_top regression: fail");
        $finish;
    end

endmodule
